// ===== rtl/binary_to_decimal_ascii_defines.svh =====
// assertion helpers shared by the rtl
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// checked on every clock edge outside reset
`define BDA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// checked on every clock edge, reset included
`define BDA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");

`endif

// ===== rtl/bda_pkg.sv =====
package bda_pkg;

  localparam int MaxDigits  = 10;
  localparam int DigitW     = 4;
  localparam int CntW       = $clog2(MaxDigits + 1);
  localparam int DigIdxW    = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0]  AutoWidth = 8'hFF;
  localparam logic [7:0]  AsciiZero = 8'h30;
  localparam logic [31:0] Recip10   = 32'hCCCCCCCD;
  localparam int          RecipShift = 35;

  typedef logic [DigitW-1:0] digit_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef digit_t [MaxDigits-1:0] digits_t;

  typedef struct packed {
    digits_t digits;
    cnt_t    count;
  } entry_t;

endpackage

// ===== rtl/bda_front.sv =====
module bda_front import bda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] value_i,
  input  logic [7:0]  digit_count_i,
  output logic        push_o,
  input  logic        push_ready_i,
  output entry_t      push_data_o
);

  typedef enum logic [1:0] {FeIdle, FeConv, FePush} fe_state_e;

  fe_state_e   state_q;
  logic [31:0] value_q, value_d;
  logic        auto_q;
  cnt_t        req_q, sig_q, step_q;
  digits_t     digits_q, digits_d;
  logic [63:0] prod;
  logic [31:0] quot, quot10;
  digit_t      rem;

  // divide by ten through the reciprocal, remainder by shift and subtract
  always_comb begin
    prod     = 64'(value_q) * 64'(Recip10);
    quot     = 32'(prod[63:RecipShift]);
    quot10   = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
    rem      = DigitW'(value_q - quot10);
    value_d  = quot;
    digits_d = digits_q >> DigitW;
    digits_d[MaxDigits-1] = rem;
  end

  assign in_ready_o = (state_q == FeIdle);
  assign push_o     = (state_q == FePush);

  always_comb begin
    push_data_o.digits = digits_q;
    if (!auto_q) begin
      push_data_o.count = req_q;
    end else if (sig_q == '0) begin
      push_data_o.count = CntW'(1);
    end else begin
      push_data_o.count = sig_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FeIdle;
    end else begin
      case (state_q)
        FeIdle: begin
          if (in_valid_i) begin
            state_q <= FeConv;
          end
        end
        FeConv: begin
          if (step_q == CntW'(MaxDigits - 1)) begin
            state_q <= FePush;
          end
        end
        FePush: begin
          if (push_ready_i) begin
            state_q <= FeIdle;
          end
        end
        default: state_q <= FeIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FeIdle && in_valid_i) begin
      value_q <= value_i;
      auto_q  <= (digit_count_i == AutoWidth);
      if (digit_count_i > 8'(MaxDigits)) begin
        req_q <= CntW'(MaxDigits);
      end else begin
        req_q <= CntW'(digit_count_i);
      end
      sig_q  <= '0;
      step_q <= '0;
    end else if (state_q == FeConv) begin
      // significant digits: steps taken while the remaining value is nonzero
      if (value_q != '0) begin
        sig_q <= CntW'(step_q + 1'b1);
      end
      value_q  <= value_d;
      digits_q <= digits_d;
      step_q   <= CntW'(step_q + 1'b1);
    end
  end

endmodule

// ===== rtl/bda_queue.sv =====
`include "binary_to_decimal_ascii_defines.svh"

module bda_queue import bda_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  output logic   push_ready_o,
  input  entry_t push_data_i,
  output logic   pop_valid_o,
  input  logic   pop_i,
  output entry_t pop_data_o
);

  entry_t           mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != QCntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= QPtrW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= QPtrW'(rd_ptr_q + 1'b1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= QCntW'(cnt_q + 1'b1);
        2'b01:   cnt_q <= QCntW'(cnt_q - 1'b1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `BDA_ASSERT(a_cnt_bound, cnt_q <= QCntW'(QueueDepth))
  `BDA_ASSERT(a_no_push_full, push_i && !push_ready_o && !do_pop |=> cnt_q == QCntW'(QueueDepth))
  `BDA_ASSERT(a_ptr_track, cnt_q == '0 |-> wr_ptr_q == rd_ptr_q)

endmodule

// ===== rtl/bda_back.sv =====
`include "binary_to_decimal_ascii_defines.svh"

module bda_back import bda_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_o,
  input  entry_t     pop_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] character_o,
  output logic       last_o
);

  logic               busy_q;
  cnt_t               pos_q;
  digits_t            digits_q;
  logic               out_valid_q;
  logic [7:0]         char_q;
  logic               last_q;
  logic               advance, term;
  logic [DigIdxW-1:0] idx;

  assign advance = busy_q && (!out_valid_q || out_ready_i);
  assign term    = advance && (pos_q == '0);
  assign pop_o   = pop_valid_i && (!busy_q || term);
  assign idx     = DigIdxW'(pos_q - 1'b1);

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // next request loads while the terminator goes out
      if (pop_o) begin
        busy_q <= 1'b1;
      end else if (term) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (pos_q == '0) begin
        char_q <= 8'h00;
        last_q <= 1'b1;
      end else begin
        char_q <= AsciiZero + 8'(digits_q[idx]);
        last_q <= 1'b0;
        pos_q  <= CntW'(pos_q - 1'b1);
      end
    end
    if (pop_o) begin
      pos_q    <= pop_data_i.count;
      digits_q <= pop_data_i.digits;
    end
  end

  `BDA_ASSERT(a_pos_bound, busy_q |-> pos_q <= CntW'(MaxDigits))
  `BDA_ASSERT(a_last_zero, out_valid_q && last_q |-> char_q == 8'h00)
  `BDA_ASSERT(a_pop_when_free, pop_o |-> !busy_q || term)

endmodule

// ===== rtl/binary_to_decimal_ascii.sv =====
// Converts a 32-bit unsigned value to decimal ASCII text, most significant digit first,
// followed by a zero terminator byte flagged by last_o. digit_count_i sets the field width
// (zero padded, high digits dropped when too long); 255 picks the significant digit count,
// counts above 10 clamp to 10, and a count of 0 gives only the terminator. A front end takes
// one request at a time, through an accept state, ten divide-by-ten steps on a reciprocal
// multiplier and a handoff state that waits for queue space, and passes the digits through a
// two-entry queue to an emitter that drives one character per cycle while out_ready_i is high,
// count plus one characters per request. With out_ready_i held high the sustained request
// rate is set by the divide-by-ten loop.
module binary_to_decimal_ascii import bda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] value_i,
  input  logic [7:0]  digit_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  character_o,
  output logic        last_o
);

  logic   push, push_ready, pop_valid, pop;
  entry_t push_data, pop_data;

  bda_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .digit_count_i(digit_count_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  bda_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_data)
  );

  bda_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_o      (pop),
    .pop_data_i (pop_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

endmodule

// ===== verif/tb_binary_to_decimal_ascii.sv =====
`timescale 1ns / 100ps

module tb_binary_to_decimal_ascii;
  import bda_pkg::*;

  localparam int RandomRequests = 400;
  localparam int CycleLimit     = 500000;
  localparam int HoldCycles     = 400;

  typedef logic [7:0] char_q_t[$];

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_exp_t;

  typedef struct {
    logic [31:0] value;
    logic [7:0]  count;
    bit          typed;
    string       text;
  } directed_row_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [31:0] value_i       = '0;
  logic [7:0]  digit_count_i = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [7:0]  character_o;
  logic        last_o;

  char_exp_t     pending_chars[$];
  directed_row_t dir_rows[$];

  int  mismatches      = 0;
  int  requests_taken  = 0;
  int  chars_checked   = 0;
  int  auto_requests   = 0;
  int  empty_requests  = 0;
  int  clamp_requests  = 0;
  int  cut_requests    = 0;
  int  cycle_cnt       = 0;
  bit  in_idle_en      = 1'b1;
  bit  out_idle_en     = 1'b1;
  bit  hold_off        = 1'b0;

  binary_to_decimal_ascii u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .digit_count_i(digit_count_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .character_o  (character_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int significant_digits(logic [31:0] value);
    int          n;
    logic [31:0] rest;
    n = 0;
    rest = value;
    do begin
      n++;
      rest = rest / 10;
    end while (rest != 0);
    return n;
  endfunction

  function automatic char_q_t predict_text(logic [31:0] value, logic [7:0] count);
    char_q_t     text;
    int          width;
    logic [31:0] rest;
    logic [3:0]  low_first[MaxDigits];
    width = (count == AutoWidth) ? significant_digits(value) : int'(count);
    if (width > MaxDigits) width = MaxDigits;
    rest = value;
    for (int k = 0; k < MaxDigits; k++) begin
      low_first[k] = 4'(rest % 10);
      rest = rest / 10;
    end
    for (int k = width - 1; k >= 0; k--) text.push_back(AsciiZero + 8'(low_first[k]));
    return text;
  endfunction

  function automatic char_q_t text_of(string s);
    char_q_t text;
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    return text;
  endfunction

  function automatic void queue_text(char_q_t text);
    foreach (text[i]) pending_chars.push_back('{ch: text[i], last: 1'b0});
    pending_chars.push_back('{ch: 8'h00, last: 1'b1});
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (mismatches < 50)
      $display("mismatch on %s: got %02h, want %02h (character %0d)", what, got, want,
               chars_checked);
    mismatches++;
  endtask

  task automatic send_request(logic [31:0] value, logic [7:0] count, bit typed, string text);
    int gap;
    gap = in_idle_en ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    value_i       <= value;
    digit_count_i <= count;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    requests_taken++;
    if (count == AutoWidth) auto_requests++;
    else if (count == 0) empty_requests++;
    else if (count > MaxDigits) clamp_requests++;
    if (count != AutoWidth && count != 0 && significant_digits(value) > int'(count))
      cut_requests++;
    if (typed) queue_text(text_of(text));
    else queue_text(predict_text(value, count));
  endtask

  function automatic logic [31:0] random_value();
    logic [31:0] p;
    int          k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4: return $urandom_range(0, 99);
      5: begin
        p = 1;
        k = $urandom_range(0, 9);
        repeat (k) p = p * 10;
        return $urandom_range(0, 1) ? p : p - 1;
      end
      6: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      7: return $urandom_range(0, 99999);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [7:0] random_count();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return AutoWidth;
      4, 5, 6, 7: return 8'($urandom_range(0, MaxDigits));
      8: return 8'($urandom_range(MaxDigits + 1, 254));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // response side
  initial begin
    int        gap;
    char_exp_t want;
    @(posedge rst_ni);
    forever begin
      gap = out_idle_en ? $urandom_range(0, 15) : 0;
      if (hold_off || gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        while (hold_off) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (pending_chars.size() == 0) begin
        report_mismatch("character with no request pending", character_o, 8'h00);
      end else begin
        want = pending_chars.pop_front();
        if (character_o !== want.ch) report_mismatch("character", character_o, want.ch);
        if (last_o !== want.last) report_mismatch("last", 8'(last_o), 8'(want.last));
      end
      chars_checked++;
    end
  end

  // long receiver stall so the queue fills and backs up the request side
  initial begin
    wait (requests_taken >= 40);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d characters still pending", cycle_cnt,
             pending_chars.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    dir_rows = '{
      '{32'd0,          8'd255, 1'b1, "0"},
      '{32'd0,          8'd0,   1'b1, ""},
      '{32'd42,         8'd0,   1'b1, ""},
      '{32'hFFFF_FFFF,  8'd255, 1'b1, "4294967295"},
      '{32'hFFFF_FFFF,  8'd10,  1'b1, "4294967295"},
      '{32'hFFFF_FFFF,  8'd11,  1'b1, "4294967295"},
      '{32'hFFFF_FFFF,  8'd254, 1'b1, "4294967295"},
      '{32'hFFFF_FFFF,  8'd3,   1'b1, "295"},
      '{32'hFFFF_FFFF,  8'd9,   1'b1, "294967295"},
      '{32'd0,          8'd10,  1'b1, "0000000000"},
      '{32'd0,          8'd1,   1'b1, "0"},
      '{32'd7,          8'd1,   1'b1, "7"},
      '{32'd9,          8'd255, 1'b1, "9"},
      '{32'd10,         8'd255, 1'b1, "10"},
      '{32'd12345,      8'd8,   1'b1, "00012345"},
      '{32'd999999999,  8'd255, 1'b1, "999999999"},
      '{32'd1000000000, 8'd255, 1'b1, "1000000000"},
      '{32'h8000_0000,  8'd255, 1'b1, "2147483648"},
      '{32'h5555_5555,  8'd128, 1'b1, "1431655765"},
      '{32'hAAAA_AAAA,  8'd255, 1'b1, "2863311530"},
      '{32'd123456789,  8'd5,   1'b0, ""},
      '{32'd3000000000, 8'd7,   1'b0, ""},
      '{32'd65535,      8'd2,   1'b0, ""},
      '{32'd100,        8'd200, 1'b0, ""}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_request(dir_rows[i].value, dir_rows[i].count, dir_rows[i].typed, dir_rows[i].text);

    for (int n = 0; n < RandomRequests; n++) begin
      if (n % 40 == 0) begin
        in_idle_en  = ($urandom_range(0, 3) != 0);
        out_idle_en = ($urandom_range(0, 3) != 0);
      end
      send_request(random_value(), random_count(), 1'b0, "");
    end
    in_valid_i <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("%0d requests, %0d characters checked in %0d cycles", requests_taken,
             chars_checked, cycle_cnt);
    $display("auto width %0d, zero count %0d, clamped count %0d, truncated field %0d",
             auto_requests, empty_requests, clamp_requests, cut_requests);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
